FILE: rtl/sop_pkg.sv
package sop_pkg;

   // Fixed field widths of the channels.
   localparam int RandW    = 31;
   localparam int RowW     = 6;
   localparam int ColW     = 6;
   localparam int CfgSideW = 7;
   localparam int ObsW     = 13;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 13;

   // Run tag kept with every store entry; an entry whose tag differs from the
   // current run's tag reads as its own position.
   localparam int EpochW = 12;

   typedef enum logic [CsrIdxW-1:0] {
      REG_GRID_ROWS      = 2'd0,
      REG_GRID_COLS      = 2'd1,
      REG_OBSTACLE_COUNT = 2'd2
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDI,
      ST_CAPA,
      ST_MOD,
      ST_RDJ,
      ST_CAPB,
      ST_WRI,
      ST_DIVB,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/sop_ifs.sv
interface sop_req_if import sop_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RandW-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink (input valid, input random_word, output ready);
endinterface

interface sop_rsp_if import sop_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RowW-1:0] cell_row;
   logic [ColW-1:0] cell_col;
   logic            is_obstacle;
   logic            last_of_run;

   modport source (output valid, output cell_row, output cell_col, output is_obstacle,
                   output last_of_run, input ready);
   modport sink (input valid, input cell_row, input cell_col, input is_obstacle,
                 input last_of_run, output ready);
endinterface

interface sop_csr_if import sop_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sop_div.sv
module sop_div #(
   parameter int DvdW = 31,
   parameter int DsrW = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [$clog2(DvdW+1)-1:0]      steps,
   input  logic [DvdW-1:0]                dividend,
   input  logic [DsrW-1:0]                divisor,
   output logic                           busy,
   output logic [DvdW-1:0]                quotient,
   output logic [DsrW-1:0]                remainder
);

   localparam int StepW = $clog2(DvdW+1);

   logic             busy_ff, busy_in;
   logic [StepW-1:0] steps_ff, steps_in;
   logic [DvdW-1:0]  dvd_ff, dvd_in;
   logic [DvdW-1:0]  quo_ff, quo_in;
   logic [DsrW-1:0]  rem_ff, rem_in;
   logic [DsrW-1:0]  dsr_ff, dsr_in;
   logic [DsrW:0]    trial;
   logic [DsrW:0]    diff;
   logic             fits;

   // One restoring step per cycle: bring down the next dividend bit and
   // subtract the divisor when it fits.
   assign trial = {rem_ff, dvd_ff[DvdW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      steps_in = steps_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = steps != '0;
         steps_in = steps;
         dvd_in   = dividend;
         quo_in   = '0;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         dvd_in   = dvd_ff << 1;
         quo_in   = {quo_ff[DvdW-2:0], fits};
         rem_in   = fits ? diff[DsrW-1:0] : trial[DsrW-1:0];
         steps_in = steps_ff - StepW'(1);
         if (steps_ff == StepW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/shuffled_obstacle_placer.sv
// Each accepted request is answered after two bit-serial divisions in the shared
// divider, one for the swap position and one for the row and column of the cell.
// The controller returns to idle after each response before it takes the next
// request; that request is taken while the previous response waits. After reset,
// and once every 4095 run restarts, the store is swept over all MAX_CELLS entries
// (4096 by default) with no request accepted.
module shuffled_obstacle_placer import sop_pkg::*; #(
   parameter int MAX_CELLS = 4096,
   parameter int MAX_SIDE  = 64
) (
   input  logic      clock,
   input  logic      reset,
   sop_req_if.sink   req_bus,
   sop_rsp_if.source rsp_bus,
   sop_csr_if.sink   csr_bus
);

   localparam int CellW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CntW  = $clog2(MAX_CELLS + 1);
   localparam int SideW = $clog2(MAX_SIDE + 1);
   localparam int DsrW  = (CntW > SideW) ? CntW : SideW;
   localparam int StepW = $clog2(RandW + 1);

   typedef struct packed {
      logic [EpochW-1:0] tag;
      logic [CellW-1:0]  idx;
   } entry_type;

   entry_type mem [MAX_CELLS];

   state_type         state_ff, state_in;
   logic [CfgSideW-1:0] rows_ff, rows_in;
   logic [CfgSideW-1:0] cols_ff, cols_in;
   logic [ObsW-1:0]     obs_ff, obs_in;
   logic [SideW-1:0]    rows_c, cols_c;
   logic [SideW-1:0]    cols_c_ff;
   logic [2*SideW-1:0]  prod;
   logic [CntW-1:0]     n_ff;
   logic [CellW-1:0]    pos_ff, pos_in;
   logic [EpochW-1:0]   epoch_ff, epoch_in;
   logic                clearing_ff, clearing_in;
   logic [CellW-1:0]    clr_addr_ff, clr_addr_in;
   logic [RandW-1:0]    rand_ff;
   logic [CellW-1:0]    j_ff, j_comb;
   logic [CellW-1:0]    a_ff, b_ff;
   entry_type           rd_ff;
   logic [CellW-1:0]    addr_q_ff;
   logic [CellW-1:0]    entry_val;
   logic                mem_we;
   logic [CellW-1:0]    mem_addr;
   entry_type           mem_wdata;
   logic                div_start, div_busy;
   logic [StepW-1:0]    div_steps;
   logic [RandW-1:0]    div_dvd, div_quo;
   logic [DsrW-1:0]     div_dsr, div_rem;
   logic                req_accept, cfg_write, out_load, last_comb, restart;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RowW-1:0]     row_ff;
   logic [ColW-1:0]     col_ff;
   logic                obst_ff, last_ff;

   // Configuration: side lengths are clamped to 1..MAX_SIDE, cell count to MAX_CELLS.
   function automatic logic [SideW-1:0] clamp_side(input logic [CfgSideW-1:0] v);
      logic [SideW-1:0] r;
      if (v == '0) begin
         r = SideW'(1);
      end else if (32'(v) > MAX_SIDE) begin
         r = SideW'(MAX_SIDE);
      end else begin
         r = SideW'(v);
      end
      return r;
   endfunction

   assign rows_c = clamp_side(rows_ff);
   assign cols_c = clamp_side(cols_ff);
   assign prod   = (2*SideW)'(rows_c) * (2*SideW)'(cols_c);

   always_ff @(posedge clock) begin
      n_ff      <= (32'(prod) > MAX_CELLS) ? CntW'(MAX_CELLS) : CntW'(prod);
      cols_c_ff <= cols_c;
   end

   assign csr_bus.ready = 1'b1;
   assign cfg_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      obs_in  = obs_ff;
      restart = 1'b0;
      if (cfg_write) begin
         case (csr_bus.index)
            REG_GRID_ROWS: begin
               rows_in = csr_bus.data[CfgSideW-1:0];
               restart = 1'b1;
            end
            REG_GRID_COLS: begin
               cols_in = csr_bus.data[CfgSideW-1:0];
               restart = 1'b1;
            end
            REG_OBSTACLE_COUNT: begin
               obs_in  = csr_bus.data[ObsW-1:0];
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      if (out_load && last_comb) begin
         restart = 1'b1;
      end
   end

   // Store access: an entry tagged with an older run reads as its own position.
   assign entry_val = (rd_ff.tag == epoch_ff) ? rd_ff.idx : addr_q_ff;
   assign j_comb    = CellW'(CntW'(div_rem) + CntW'(pos_ff));
   assign last_comb = pos_ff == CellW'(n_ff - CntW'(1));

   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && !clearing_ff;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_steps = StepW'(RandW);
      div_dvd   = rand_ff;
      div_dsr   = DsrW'(n_ff - CntW'(pos_ff));
      mem_we    = 1'b0;
      mem_addr  = pos_ff;
      mem_wdata = '{tag: epoch_ff, idx: a_ff};
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (clearing_ff) begin
               mem_we    = 1'b1;
               mem_addr  = clr_addr_ff;
               mem_wdata = '{tag: '0, idx: '0};
            end else if (req_bus.valid) begin
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            div_start = 1'b1;
            state_in  = ST_CAPA;
         end
         ST_CAPA: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (!div_busy) begin
               state_in = ST_RDJ;
            end
         end
         ST_RDJ: begin
            mem_addr = j_comb;
            state_in = ST_CAPB;
         end
         ST_CAPB: begin
            mem_we    = 1'b1;
            mem_addr  = j_ff;
            div_start = 1'b1;
            div_steps = StepW'(CellW);
            div_dvd   = RandW'(entry_val) << (RandW - CellW);
            div_dsr   = DsrW'(cols_c_ff);
            state_in  = ST_WRI;
         end
         ST_WRI: begin
            mem_we    = 1'b1;
            mem_wdata = '{tag: epoch_ff, idx: b_ff};
            state_in  = ST_DIVB;
         end
         ST_DIVB: begin
            if (!div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Run bookkeeping. Restarts bump the run tag; when the tag runs out the
   // store is swept back to tag zero before the next transaction.
   always_comb begin
      pos_in      = pos_ff;
      epoch_in    = epoch_ff;
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + CellW'(1);
         if (clr_addr_ff == CellW'(MAX_CELLS - 1)) begin
            clearing_in = 1'b0;
         end
      end
      if (out_load) begin
         pos_in = pos_ff + CellW'(1);
      end
      if (restart) begin
         pos_in = '0;
         if (!clearing_ff) begin
            if (epoch_ff == '1) begin
               epoch_in    = EpochW'(1);
               clearing_in = 1'b1;
               clr_addr_in = '0;
            end else begin
               epoch_in = epoch_ff + EpochW'(1);
            end
         end
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= CfgSideW'(1);
         cols_ff      <= CfgSideW'(1);
         obs_ff       <= '0;
         pos_ff       <= '0;
         epoch_ff     <= EpochW'(1);
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         obs_ff       <= obs_in;
         pos_ff       <= pos_in;
         epoch_ff     <= epoch_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rand_ff <= req_bus.random_word;
      end
      if (state_ff == ST_CAPA) begin
         a_ff <= entry_val;
      end
      if (state_ff == ST_RDJ) begin
         j_ff <= j_comb;
      end
      if (state_ff == ST_CAPB) begin
         b_ff <= entry_val;
      end
      if (out_load) begin
         row_ff  <= RowW'(div_quo);
         col_ff  <= ColW'(div_rem);
         obst_ff <= 32'(pos_ff) < 32'(obs_ff);
         last_ff <= last_comb;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff     <= mem[mem_addr];
      addr_q_ff <= mem_addr;
   end

   sop_div #(
      .DvdW (RandW),
      .DsrW (DsrW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .steps     (div_steps),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.cell_row    = row_ff;
   assign rsp_bus.cell_col    = col_ff;
   assign rsp_bus.is_obstacle = obst_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule
